@@ rtl/core/tfn_pkg.sv @@
// ----------------------------------------------------------------------------
// tfn_pkg: shared types and constants for the tet face normal scaling unit
// Fixed-point formats, face codes and the beat layouts that travel along
// the square-root and divider cell chains.
// ----------------------------------------------------------------------------
package tfn_pkg;

   localparam int FRAC_BITS = 20;
   localparam int UNIT_FRAC = 30;
   localparam int MAG_W     = 34;
   localparam int SQ_STEPS  = 32;
   localparam int DIV_STEPS = 32;
   localparam int LANES     = 4;

   localparam logic [1:0] FACE_T   = 2'd0;
   localparam logic [1:0] FACE_S   = 2'd1;
   localparam logic [1:0] FACE_RST = 2'd2;
   localparam logic [1:0] FACE_R   = 2'd3;

   // digit-by-digit square root working set
   typedef struct packed {
      logic [33:0] rem;
      logic [31:0] root;
      logic [63:0] rad;
   } sq_type;

   // data riding alongside the square root
   typedef struct packed {
      logic [2:0][MAG_W-1:0] mag;
      logic [2:0]            neg;
      logic [1:0]            k;
      logic [31:0]           jac;
   } sq_side_type;

   // one restoring-division lane: remainder, divisor, dividend/quotient
   typedef struct packed {
      logic [MAG_W-1:0] rem;
      logic [MAG_W-1:0] dvs;
      logic [31:0]      lo;
   } dv_lane_type;

   typedef dv_lane_type [LANES-1:0] dv_lanes_type;

   // data riding alongside the dividers
   typedef struct packed {
      logic [2:0]  neg;
      logic        jpos;
      logic        inv_ovf;
      logic        degen;
      logic [64:0] prod;
   } dv_side_type;

endpackage

@@ rtl/core/tet_face_normal_scaling_unit.sv @@
// ----------------------------------------------------------------------------
// tet_face_normal_scaling_unit: face unit normal and surface Jacobian
// Selects the outward face normal, takes its length through a square-root
// cell chain, then divides for the unit normal and 1/J in a divider chain.
//
//   channel | dir | beat
//   req_*   | in  | face, nine metric terms, Jacobian
//   rsp_*   | out | unit normal, surf_jac, inv_jac, degenerate
//
// One beat enters per cycle unless the pipe holds. The path is 4 front stages, 32
// square-root cells, 1 prep stage, 32 divider cells, 1 output stage, plus
// the output register. The cell chains set the latency.
// Reset empties the pipe. The pipe holds while the output register and its
// skid stage are both full; otherwise beats keep flowing.
// ----------------------------------------------------------------------------
module tet_face_normal_scaling_unit import tfn_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_face,
   input  logic signed [31:0] req_rx,
   input  logic signed [31:0] req_ry,
   input  logic signed [31:0] req_rz,
   input  logic signed [31:0] req_sx,
   input  logic signed [31:0] req_sy,
   input  logic signed [31:0] req_sz,
   input  logic signed [31:0] req_tx,
   input  logic signed [31:0] req_ty,
   input  logic signed [31:0] req_tz,
   input  logic signed [31:0] req_jac,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_unit_nx,
   output logic signed [31:0] rsp_unit_ny,
   output logic signed [31:0] rsp_unit_nz,
   output logic [39:0]        rsp_surf_jac,
   output logic [31:0]        rsp_inv_jac,
   output logic               rsp_degenerate
);

   typedef struct packed {
      logic [2:0][31:0] unit;
      logic [39:0]      surf_jac;
      logic [31:0]      inv_jac;
      logic             degen;
   } res_type;

   localparam logic [31:0] UNIT_ONE = 32'(64'd1 << UNIT_FRAC);
   localparam logic [65:0] HALF_LSB = 66'(66'd1 << (FRAC_BITS - 1));
   localparam logic [63:0] INV_NUM  = 64'(64'd1 << (2 * FRAC_BITS));
   localparam logic [65:0] SJ_MAX   = 66'(40'hFF_FFFF_FFFF);

   logic en;
   logic skid_v_ff;

   assign en        = !skid_v_ff;
   assign req_ready = en;

   // ---------------- stage 1: pick the face normal
   logic                    s1_v_ff;
   logic signed [2:0][33:0] s1_n_ff, s1_n_in;
   logic [31:0]             s1_jac_ff;

   function automatic logic signed [33:0] ext(input logic signed [31:0] v);
      return 34'(v);
   endfunction

   always_comb begin
      case (req_face)
         FACE_T: begin
            s1_n_in[0] = -ext(req_tx);
            s1_n_in[1] = -ext(req_ty);
            s1_n_in[2] = -ext(req_tz);
         end
         FACE_S: begin
            s1_n_in[0] = -ext(req_sx);
            s1_n_in[1] = -ext(req_sy);
            s1_n_in[2] = -ext(req_sz);
         end
         FACE_RST: begin
            s1_n_in[0] = ext(req_rx) + ext(req_sx) + ext(req_tx);
            s1_n_in[1] = ext(req_ry) + ext(req_sy) + ext(req_ty);
            s1_n_in[2] = ext(req_rz) + ext(req_sz) + ext(req_tz);
         end
         FACE_R: begin
            s1_n_in[0] = -ext(req_rx);
            s1_n_in[1] = -ext(req_ry);
            s1_n_in[2] = -ext(req_rz);
         end
         default: begin
            s1_n_in = '0;
         end
      endcase
   end

   // ---------------- stage 2: magnitudes and range shift
   logic              s2_v_ff;
   sq_side_type       s2_side_ff, s2_side_in;
   logic [2:0][30:0]  s2_sh_ff, s2_sh_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s2_side_in.neg[i] = s1_n_ff[i][33];
         s2_side_in.mag[i] = s1_n_ff[i][33] ? MAG_W'(-s1_n_ff[i]) : MAG_W'(s1_n_ff[i]);
      end
      if ((s2_side_in.mag[0][33:31] | s2_side_in.mag[1][33:31]
           | s2_side_in.mag[2][33:31]) == 3'b000) begin
         s2_side_in.k = 2'd0;
      end else if ((s2_side_in.mag[0][33:32] | s2_side_in.mag[1][33:32]
                    | s2_side_in.mag[2][33:32]) == 2'b00) begin
         s2_side_in.k = 2'd1;
      end else begin
         s2_side_in.k = 2'd2;
      end
      for (int i = 0; i < 3; i++) begin
         s2_sh_in[i] = 31'(s2_side_in.mag[i] >> s2_side_in.k);
      end
      s2_side_in.jac = s1_jac_ff;
   end

   // ---------------- stage 3: squares, stage 4: sum
   logic             s3_v_ff;
   sq_side_type      s3_side_ff;
   logic [2:0][61:0] s3_sq_ff;
   logic             s4_v_ff;
   sq_side_type      s4_side_ff;
   logic [63:0]      s4_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= req_valid;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
      end
      if (en) begin
         s1_n_ff    <= s1_n_in;
         s1_jac_ff  <= req_jac;
         s2_side_ff <= s2_side_in;
         s2_sh_ff   <= s2_sh_in;
         s3_side_ff <= s2_side_ff;
         for (int i = 0; i < 3; i++) begin
            s3_sq_ff[i] <= 62'(s2_sh_ff[i]) * 62'(s2_sh_ff[i]);
         end
         s4_side_ff <= s3_side_ff;
         s4_sum_ff  <= 64'(s3_sq_ff[0]) + 64'(s3_sq_ff[1]) + 64'(s3_sq_ff[2]);
      end
   end

   // ---------------- square-root cell chain
   logic        sq_v    [0:SQ_STEPS];
   sq_type      sq_d    [0:SQ_STEPS];
   sq_side_type sq_side [0:SQ_STEPS];

   assign sq_v[0]    = s4_v_ff;
   assign sq_d[0]    = '{rem: '0, root: '0, rad: s4_sum_ff};
   assign sq_side[0] = s4_side_ff;

   for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sq
      tfn_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (sq_v[g]),
         .in_data   (sq_d[g]),
         .in_side   (sq_side[g]),
         .out_valid (sq_v[g+1]),
         .out_data  (sq_d[g+1]),
         .out_side  (sq_side[g+1])
      );
   end

   // ---------------- prep: length, dividends, J product
   sq_side_type      pq;
   logic [MAG_W-1:0] len;
   logic [30:0]      jm;
   logic [63:0]      num [3];
   logic [63:0]      inum;
   logic             pv_ff;
   dv_lanes_type     pd_ff, pd_in;
   dv_side_type      ps_ff, ps_in;

   always_comb begin
      pq  = sq_side[SQ_STEPS];
      len = MAG_W'(sq_d[SQ_STEPS].root) << pq.k;
      jm  = pq.jac[30:0];
      for (int i = 0; i < 3; i++) begin
         num[i] = (64'(pq.mag[i]) << UNIT_FRAC) + 64'(len >> 1);
         pd_in[i].rem = MAG_W'(num[i][63:32]);
         pd_in[i].lo  = num[i][31:0];
         pd_in[i].dvs = len;
      end
      inum = INV_NUM + 64'(jm >> 1);
      pd_in[3].rem = MAG_W'(inum[63:32]);
      pd_in[3].lo  = inum[31:0];
      pd_in[3].dvs = MAG_W'(jm);
      ps_in.neg     = pq.neg;
      ps_in.jpos    = !pq.jac[31] && (pq.jac != '0);
      ps_in.inv_ovf = MAG_W'(inum[63:32]) >= MAG_W'(jm);
      ps_in.degen   = (len == '0) || !ps_in.jpos;
      ps_in.prod    = 65'(len) * 65'(jm);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else if (en) begin
         pv_ff <= sq_v[SQ_STEPS];
      end
      if (en) begin
         pd_ff <= pd_in;
         ps_ff <= ps_in;
      end
   end

   // ---------------- divider cell chain
   logic         dv_v    [0:DIV_STEPS];
   dv_lanes_type dv_d    [0:DIV_STEPS];
   dv_side_type  dv_side [0:DIV_STEPS];

   assign dv_v[0]    = pv_ff;
   assign dv_d[0]    = pd_ff;
   assign dv_side[0] = ps_ff;

   for (genvar g = 0; g < DIV_STEPS; g++) begin : g_dv
      tfn_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (dv_v[g]),
         .in_data   (dv_d[g]),
         .in_side   (dv_side[g]),
         .out_valid (dv_v[g+1]),
         .out_data  (dv_d[g+1]),
         .out_side  (dv_side[g+1])
      );
   end

   // ---------------- finish: clamp, sign, round, saturate
   dv_side_type  fs;
   dv_lanes_type fd;
   logic [31:0]  q;
   logic [65:0]  sj_r;
   res_type      fin;

   always_comb begin
      fs = dv_side[DIV_STEPS];
      fd = dv_d[DIV_STEPS];
      q  = '0;
      for (int i = 0; i < 3; i++) begin
         q = (fd[i].lo > UNIT_ONE) ? UNIT_ONE : fd[i].lo;
         if (fs.degen) begin
            fin.unit[i] = '0;
         end else begin
            fin.unit[i] = fs.neg[i] ? -q : q;
         end
      end
      sj_r = (66'(fs.prod) + HALF_LSB) >> FRAC_BITS;
      if (!fs.jpos) begin
         fin.surf_jac = '0;
         fin.inv_jac  = '0;
      end else begin
         fin.surf_jac = (sj_r > SJ_MAX) ? SJ_MAX[39:0] : sj_r[39:0];
         fin.inv_jac  = fs.inv_ovf ? '1 : fd[3].lo;
      end
      fin.degen = fs.degen;
   end

   logic    fv_ff;
   res_type fr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= 1'b0;
      end else if (en) begin
         fv_ff <= dv_v[DIV_STEPS];
      end
      if (en) begin
         fr_ff <= fin;
      end
   end

   // ---------------- output register with skid stage
   logic    out_v_ff;
   res_type out_ff, skid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (rsp_ready) begin
            out_ff    <= skid_ff;
            skid_v_ff <= 1'b0;
         end
      end else if (out_v_ff && !rsp_ready) begin
         if (fv_ff) begin
            skid_ff   <= fr_ff;
            skid_v_ff <= 1'b1;
         end
      end else begin
         out_v_ff <= fv_ff;
         if (fv_ff) begin
            out_ff <= fr_ff;
         end
      end
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_unit_nx    = out_ff.unit[0];
   assign rsp_unit_ny    = out_ff.unit[1];
   assign rsp_unit_nz    = out_ff.unit[2];
   assign rsp_surf_jac   = out_ff.surf_jac;
   assign rsp_inv_jac    = out_ff.inv_jac;
   assign rsp_degenerate = out_ff.degen;

endmodule

@@ rtl/core/tfn_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// tfn_sqrt_cell: one step of the pipelined integer square root
// Brings down two radicand bits, tries the next root bit, registers the beat.
// ----------------------------------------------------------------------------
module tfn_sqrt_cell import tfn_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  sq_type      in_data,
   input  sq_side_type in_side,
   output logic        out_valid,
   output sq_type      out_data,
   output sq_side_type out_side
);

   logic        valid_ff;
   sq_type      data_ff, data_in;
   sq_side_type side_ff;
   logic [35:0] rem2;
   logic [35:0] trial;
   logic        ge;

   always_comb begin
      rem2  = {in_data.rem, in_data.rad[63:62]};
      trial = {2'b00, in_data.root, 2'b01};
      ge    = rem2 >= trial;
      data_in.rad  = {in_data.rad[61:0], 2'b00};
      data_in.root = {in_data.root[30:0], ge};
      data_in.rem  = ge ? 34'(rem2 - trial) : rem2[33:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         data_ff <= data_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
   assign out_side  = side_ff;

endmodule

@@ rtl/core/tfn_div_cell.sv @@
// ----------------------------------------------------------------------------
// tfn_div_cell: one quotient bit of four restoring dividers in parallel
// Each lane shifts in a dividend bit, subtracts when it fits, registers.
// ----------------------------------------------------------------------------
module tfn_div_cell import tfn_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic         in_valid,
   input  dv_lanes_type in_data,
   input  dv_side_type  in_side,
   output logic         out_valid,
   output dv_lanes_type out_data,
   output dv_side_type  out_side
);

   logic         valid_ff;
   dv_lanes_type data_ff, data_in;
   dv_side_type  side_ff;
   logic [LANES-1:0][MAG_W:0] rem2;
   logic [LANES-1:0]          ge;

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         rem2[i] = {in_data[i].rem, in_data[i].lo[31]};
         ge[i]   = rem2[i] >= {1'b0, in_data[i].dvs};
         data_in[i].dvs = in_data[i].dvs;
         data_in[i].lo  = {in_data[i].lo[30:0], ge[i]};
         data_in[i].rem = ge[i] ? MAG_W'(rem2[i] - {1'b0, in_data[i].dvs})
                                : rem2[i][MAG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         data_ff <= data_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
   assign out_side  = side_ff;

endmodule

@@ tb/sv/tb_tet_face_normal_scaling_unit.sv @@
// ----------------------------------------------------------------------------
// tb_tet_face_normal_scaling_unit: stream test of the face normal unit
// Drives face nodes with random idling on both channels, predicts the unit
// normal, surface Jacobian and 1/J per beat and checks results in order.
// ----------------------------------------------------------------------------
module tb_tet_face_normal_scaling_unit import tfn_pkg::*;;

   typedef struct packed {
      logic signed [31:0] nx;
      logic signed [31:0] ny;
      logic signed [31:0] nz;
      logic [39:0]        sj;
      logic [31:0]        ij;
      logic               dg;
   } face_res_type;

   class face_scoreboard;
      face_res_type pending[$];
      int        mismatches = 0;
      int        checked = 0;

      function automatic logic [63:0] sqrt_floor(logic [63:0] x);
         logic [63:0] r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > x) b = b >> 2;
         while (b != 0) begin
            if (x >= r + b) begin
               x = x - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      function automatic logic [31:0] unit_of(logic signed [63:0] c, logic [63:0] len);
         logic [63:0] a, q;
         a = c < 0 ? -c : c;
         q = ((a << UNIT_FRAC) + (len >> 1)) / len;
         if (q > (64'd1 << UNIT_FRAC)) q = 64'd1 << UNIT_FRAC;
         if (c < 0) q = -q;
         return q[31:0];
      endfunction

      function void note_node(logic [1:0] face, logic signed [31:0] m[9],
                              logic signed [31:0] jac);
         logic signed [63:0] n[3];
         logic [63:0]        a[3], mx, s, len;
         logic [127:0]       p;
         int                 k;
         face_res_type       e;
         for (int i = 0; i < 3; i++) begin
            case (face)
               FACE_T:   n[i] = -64'(m[6+i]);
               FACE_S:   n[i] = -64'(m[3+i]);
               FACE_RST: n[i] = 64'(m[i]) + 64'(m[3+i]) + 64'(m[6+i]);
               default:  n[i] = -64'(m[i]);
            endcase
            a[i] = n[i] < 0 ? -n[i] : n[i];
         end
         mx = a[0];
         if (a[1] > mx) mx = a[1];
         if (a[2] > mx) mx = a[2];
         k = mx < (64'd1 << 31) ? 0 : (mx < (64'd1 << 32) ? 1 : 2);
         s = 0;
         for (int i = 0; i < 3; i++) s = s + (a[i] >> k) * (a[i] >> k);
         len = sqrt_floor(s) << k;
         e = '0;
         e.dg = (len == 0) || (jac <= 0);
         if (jac > 0) begin
            p = (128'(len) * 128'(jac) + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
            e.sj = p > 128'hFF_FFFF_FFFF ? 40'hFF_FFFF_FFFF : p[39:0];
            p = ((128'd1 << (2 * FRAC_BITS)) + 128'(jac >>> 1)) / 128'(jac);
            e.ij = p > 128'hFFFF_FFFF ? 32'hFFFF_FFFF : p[31:0];
         end
         if (!e.dg) begin
            e.nx = unit_of(n[0], len);
            e.ny = unit_of(n[1], len);
            e.nz = unit_of(n[2], len);
         end
         pending.push_back(e);
      endfunction

      function void check_result(face_res_type got);
         face_res_type e;
         checked++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat %h", got);
            return;
         end
         e = pending.pop_front();
         if (got !== e) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: exp nx %h ny %h nz %h sj %h ij %h dg %b / got %h %h %h %h %h %b",
                        e.nx, e.ny, e.nz, e.sj, e.ij, e.dg,
                        got.nx, got.ny, got.nz, got.sj, got.ij, got.dg);
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic req_valid = 0, rsp_ready = 0;
   logic req_ready, rsp_valid;
   logic [1:0] req_face = 0;
   logic signed [31:0] req_rx = 0, req_ry = 0, req_rz = 0, req_sx = 0, req_sy = 0;
   logic signed [31:0] req_sz = 0, req_tx = 0, req_ty = 0, req_tz = 0, req_jac = 0;
   logic signed [31:0] rsp_unit_nx, rsp_unit_ny, rsp_unit_nz;
   logic [39:0] rsp_surf_jac;
   logic [31:0] rsp_inv_jac;
   logic rsp_degenerate;

   tet_face_normal_scaling_unit dut (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   face_scoreboard board = new();
   bit  calm = 0;
   int  idle_cycles = 0;
   int  sent = 0;

   // random value that often hits the extremes or small magnitudes
   function automatic logic [31:0] pick_term();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'(int'($urandom_range(0, 4194304)) - 2097152);
         3: return 0;
         default: return $urandom();
      endcase
   endfunction

   task automatic send_node(logic [1:0] face, logic signed [31:0] m[9], logic signed [31:0] j);
      int gap;
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 16);
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_face <= face;
      {req_rx, req_ry, req_rz} <= {m[0], m[1], m[2]};
      {req_sx, req_sy, req_sz} <= {m[3], m[4], m[5]};
      {req_tx, req_ty, req_tz} <= {m[6], m[7], m[8]};
      req_jac <= j;
      // hold until the beat is taken
      do @(posedge clock); while (!req_ready);
      board.note_node(face, m, j);
      sent++;
   endtask

   // result side: random stall bursts, then capture
   always @(posedge clock) begin
      if (rsp_valid && rsp_ready)
         board.check_result({rsp_unit_nx, rsp_unit_ny, rsp_unit_nz,
                             rsp_surf_jac, rsp_inv_jac, rsp_degenerate});
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   initial begin
      int stall;
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 0;
            stall = $urandom_range(1, 16);
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1;
      end
   end

   initial begin
      @(posedge clock);
      wait (idle_cycles >= 2000);
      $display("FAIL tet_face_normal_scaling_unit");
      $finish;
   end

   initial begin
      logic signed [31:0] m[9];
      logic signed [31:0] j;
      repeat (3) @(posedge clock);
      reset <= 0;
      // directed: every face, extreme terms, zero normal, bad Jacobians
      for (int f = 0; f < 4; f++) begin
         foreach (m[i]) m[i] = 32'sh0010_0000 * (i + 1);
         send_node(2'(f), m, 32'sh0010_0000);
         foreach (m[i]) m[i] = 32'h8000_0000;
         send_node(2'(f), m, 32'h7FFF_FFFF);
         foreach (m[i]) m[i] = 32'h7FFF_FFFF;
         send_node(2'(f), m, 1);
         foreach (m[i]) m[i] = 0;
         send_node(2'(f), m, 32'sh0000_8000);
         foreach (m[i]) m[i] = 32'sh0000_1000;
         send_node(2'(f), m, 0);
         send_node(2'(f), m, 32'h8000_0000);
      end
      for (int n = 0; n < 1150; n++) begin
         if (n == 950) calm = 1;
         foreach (m[i]) m[i] = pick_term();
         case ($urandom_range(0, 5))
            0: j = $urandom();
            1: j = $urandom_range(1, 64);
            2: j = -$urandom_range(0, 64);
            default: j = $urandom_range(1, 32'h3FFF_FFFF);
         endcase
         send_node(2'($urandom_range(0, 3)), m, j);
      end
      req_valid <= 0;
      wait (board.pending.size() == 0);
      repeat (100) @(posedge clock);
      $display("sent %0d face nodes over all four faces, %0d results checked",
               sent, board.checked);
      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("PASS tet_face_normal_scaling_unit");
      else
         $display("FAIL tet_face_normal_scaling_unit");
      $finish;
   end
endmodule

@@ sim.f @@
rtl/core/tfn_pkg.sv
rtl/core/tfn_sqrt_cell.sv
rtl/core/tfn_div_cell.sv
rtl/core/tet_face_normal_scaling_unit.sv
tb/sv/tb_tet_face_normal_scaling_unit.sv
